// ===== src/isotp_pkg.sv =====
// Shared types and constants for the ISO-TP frame reassembler.
package isotp_pkg;

    // Frame type codes (high nibble of the PCI byte)
    localparam logic [3:0] PCI_TYPE_SF = 4'h0;
    localparam logic [3:0] PCI_TYPE_FF = 4'h1;
    localparam logic [3:0] PCI_TYPE_CF = 4'h2;

    // Result frame kinds
    localparam logic [1:0] KIND_SF = 2'd0;
    localparam logic [1:0] KIND_FF = 2'd1;
    localparam logic [1:0] KIND_CF = 2'd2;

    // Sizes
    localparam int          LEN_W      = 12;
    localparam int          OUT_BYTES  = 7;
    localparam logic [2:0]  MAX_BYTES  = 3'd7;
    localparam logic [2:0]  FF_BYTES   = 3'd6;

    // One CAN frame: PCI byte plus payload bytes 1..7
    typedef struct packed {
        logic [7:0]      pci;
        logic [7:1][7:0] data;
    } frame_t;

    // One delivered result
    typedef struct packed {
        logic [1:0]                kind;
        logic [OUT_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      msg_end;
    } result_t;

    // Decoder output toward the result register
    typedef struct packed {
        logic    produce;
        result_t res;
    } decode_out_t;

endpackage

// ===== src/isotp_decode.sv =====
// Frame decoder: PCI decode, length tracking state and result formatting.
module isotp_decode
    import isotp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_t      frame,
    input  logic        advance,
    output decode_out_t dec
);

    logic             receiving_reg, receiving_next;
    logic [LEN_W-1:0] target_reg, target_next;
    logic [LEN_W-1:0] rcvd_reg, rcvd_next;

    logic [3:0]       ftype;
    logic [2:0]       sf_len;
    logic [LEN_W-1:0] remain;
    logic [2:0]       cf_n;
    logic [LEN_W-1:0] cf_total;
    logic             cf_end;
    logic [2:0]       cnt;

    assign ftype  = frame.pci[7:4];
    // Length nibble clamped to the seven bytes a frame can carry
    assign sf_len = frame.pci[3] ? MAX_BYTES : frame.pci[2:0];

    // Consecutive frame: bytes still owed, at most seven
    always_comb
    begin
        remain = target_reg - rcvd_reg;
        if (rcvd_reg >= target_reg)
            cf_n = 3'd0;
        else if (remain > LEN_W'(MAX_BYTES))
            cf_n = MAX_BYTES;
        else
            cf_n = remain[2:0];
        // no wrap: the sum passes target_reg only if rcvd_reg already did
        cf_total = rcvd_reg + LEN_W'(cf_n);
        cf_end   = (cf_total >= target_reg);
    end

    // Classify the frame, build the result and the next state
    always_comb
    begin
        receiving_next  = receiving_reg;
        target_next     = target_reg;
        rcvd_next       = rcvd_reg;
        dec.produce     = 1'b0;
        dec.res.kind    = KIND_SF;
        dec.res.msg_end = 1'b0;
        cnt             = 3'd0;
        dec.res.bytes   = '0;
        priority if (ftype == PCI_TYPE_SF)
        begin
            dec.produce     = 1'b1;
            dec.res.kind    = KIND_SF;
            dec.res.msg_end = 1'b1;
            cnt             = sf_len;
        end
        else if (ftype == PCI_TYPE_FF)
        begin
            dec.produce     = 1'b1;
            dec.res.kind    = KIND_FF;
            cnt             = FF_BYTES;
            receiving_next  = 1'b1;
            target_next     = {frame.pci[3:0], frame.data[1]};
            rcvd_next       = LEN_W'(FF_BYTES);
        end
        else if (ftype == PCI_TYPE_CF && receiving_reg)
        begin
            dec.produce     = 1'b1;
            dec.res.kind    = KIND_CF;
            dec.res.msg_end = cf_end;
            cnt             = cf_n;
            if (cf_end)
            begin
                receiving_next = 1'b0;
                target_next    = '0;
                rcvd_next      = '0;
            end
            else
            begin
                rcvd_next = cf_total;
            end
        end
        else
        begin
            dec.produce = 1'b0;
        end
        dec.res.count = cnt;

        // Byte lanes, zero above the count
        if (ftype == PCI_TYPE_FF)
        begin
            for (int k = 0; k < OUT_BYTES - 1; k++)
                dec.res.bytes[k] = frame.data[3'(k + 2)];
            dec.res.bytes[OUT_BYTES-1] = 8'h00;
        end
        else
        begin
            for (int k = 0; k < OUT_BYTES; k++)
                dec.res.bytes[k] = (3'(k) < cnt) ? frame.data[3'(k + 1)] : 8'h00;
        end
    end

    // Reassembly state, updated as each frame leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            target_reg    <= '0;
            rcvd_reg      <= '0;
        end
        else if (advance)
        begin
            receiving_reg <= receiving_next;
            target_reg    <= target_next;
            rcvd_reg      <= rcvd_next;
        end
    end

endmodule

// ===== src/isotp_frame_reassembler_unit.sv =====
// ISO-TP frame reassembler: top level with input and result registers.
//
// Input channel: one 8-byte CAN frame per request (pci_byte, data_byte_1..7),
// taken on a rising edge with in_valid high and in_stall low.
// Output channel: one result per single, first or in-message consecutive
// frame (frame_kind, out_byte_0..6, byte_count, message_end), taken with
// out_valid high and out_stall low. Other frames, and consecutive frames
// outside a message, produce nothing.
// Path: a frame is held in the input register and decoded, and its result is
// written into the result register, from which the output is driven.
// Throughput: one frame per cycle while out_stall is low; the decode logic
// between the two registers is a single pass, and the length state updates
// as each frame moves into the result register.
// Stall: while out_stall holds a result, the next frame waits in the input
// register; in_stall rises only when both registers are full and the
// output is stalled.
// Reset: rst_n clears both valid flags and the reassembly state (idle,
// no message in progress).
module isotp_frame_reassembler_unit
    import isotp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] pci_byte,
    input  logic [7:0] data_byte_1,
    input  logic [7:0] data_byte_2,
    input  logic [7:0] data_byte_3,
    input  logic [7:0] data_byte_4,
    input  logic [7:0] data_byte_5,
    input  logic [7:0] data_byte_6,
    input  logic [7:0] data_byte_7,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] frame_kind,
    output logic [7:0] out_byte_0,
    output logic [7:0] out_byte_1,
    output logic [7:0] out_byte_2,
    output logic [7:0] out_byte_3,
    output logic [7:0] out_byte_4,
    output logic [7:0] out_byte_5,
    output logic [7:0] out_byte_6,
    output logic [2:0] byte_count,
    output logic       message_end
);

    logic        in_valid_reg, in_valid_next;
    frame_t      frame_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg;
    logic        advance;
    logic        take_in;
    decode_out_t dec;

    // Pipeline control
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        if (take_in)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance && dec.produce)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            frame_reg.pci     <= pci_byte;
            frame_reg.data[1] <= data_byte_1;
            frame_reg.data[2] <= data_byte_2;
            frame_reg.data[3] <= data_byte_3;
            frame_reg.data[4] <= data_byte_4;
            frame_reg.data[5] <= data_byte_5;
            frame_reg.data[6] <= data_byte_6;
            frame_reg.data[7] <= data_byte_7;
        end
    end

    // Decode and state
    isotp_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_reg),
        .advance (advance),
        .dec     (dec)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance && dec.produce)
            result_reg <= dec.res;
    end

    assign out_valid   = out_valid_reg;
    assign frame_kind  = result_reg.kind;
    assign out_byte_0  = result_reg.bytes[0];
    assign out_byte_1  = result_reg.bytes[1];
    assign out_byte_2  = result_reg.bytes[2];
    assign out_byte_3  = result_reg.bytes[3];
    assign out_byte_4  = result_reg.bytes[4];
    assign out_byte_5  = result_reg.bytes[5];
    assign out_byte_6  = result_reg.bytes[6];
    assign byte_count  = result_reg.count;
    assign message_end = result_reg.msg_end;

endmodule

// ===== src/isotp_checker.sv =====
// Port-level checks for the ISO-TP frame reassembler, bound to the top level.
module isotp_checker
    import isotp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] frame_kind,
    input logic [7:0] out_byte_0,
    input logic [2:0] byte_count,
    input logic       message_end
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_kind)
            && $stable(byte_count) && $stable(message_end))
        else $error("stalled result changed");

    // A single frame always completes its message
    a_sf_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind == KIND_SF |-> message_end)
        else $error("single frame without message end");

    // A first frame carries six bytes and never ends a message
    a_ff_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind == KIND_FF |-> byte_count == FF_BYTES && !message_end)
        else $error("first frame result malformed");

    // An empty result reads zero on lane 0
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count == 3'd0 |-> out_byte_0 == 8'h00)
        else $error("empty result carries data");

endmodule

bind isotp_frame_reassembler_unit isotp_checker u_isotp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_kind  (frame_kind),
    .out_byte_0  (out_byte_0),
    .byte_count  (byte_count),
    .message_end (message_end)
);

// ===== tb/sv/tb.sv =====
// Testbench for the ISO-TP frame reassembler: predicts each delivered frame and checks it.
`timescale 1ns / 1ps

module tb
    import isotp_pkg::*;
();

    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 950;

    // Tracks reassembly state and the payloads the block should deliver
    class isotp_tracker;
        bit          rx_active;
        logic [11:0] tgt_len;
        logic [11:0] rcv_cnt;
        result_t     pending_payloads[$];
        int          errors;
        int          produced;
        int          taken;

        function new();
            rx_active = 1'b0;
            tgt_len   = '0;
            rcv_cnt   = '0;
            errors    = 0;
            produced  = 0;
            taken     = 0;
        endfunction

        function int pending();
            return pending_payloads.size();
        endfunction

        // Work out what one accepted frame delivers
        function void take_frame(frame_t f);
            result_t     r;
            logic [7:0]  fb [0:7];
            logic [11:0] left;
            int          first;
            int          n;
            bit          emit;
            r = '0;
            first = 1;
            n = 0;
            emit = 1'b1;
            taken++;
            fb[0] = f.pci;
            for (int k = 1; k < 8; k++)
                fb[k] = f.data[k];
            case (f.pci[7:4])
                PCI_TYPE_SF:
                begin
                    n = (f.pci[3:0] > 4'd7) ? 7 : int'(f.pci[3:0]);
                    r.kind = KIND_SF;
                    r.msg_end = 1'b1;
                end
                PCI_TYPE_FF:
                begin
                    // a new first frame abandons any message in progress
                    tgt_len = {f.pci[3:0], f.data[1]};
                    rx_active = 1'b1;
                    rcv_cnt = 12'd6;
                    first = 2;
                    n = 6;
                    r.kind = KIND_FF;
                    r.msg_end = 1'b0;
                end
                PCI_TYPE_CF:
                begin
                    if (!rx_active)
                        emit = 1'b0;
                    else
                    begin
                        if (rcv_cnt < tgt_len)
                        begin
                            left = tgt_len - rcv_cnt;
                            n = (left > 12'd7) ? 7 : int'(left);
                        end
                        rcv_cnt = rcv_cnt + 12'(n);
                        r.kind = KIND_CF;
                        r.msg_end = 1'b0;
                        if (rcv_cnt >= tgt_len)
                        begin
                            r.msg_end = 1'b1;
                            rx_active = 1'b0;
                            tgt_len = '0;
                            rcv_cnt = '0;
                        end
                    end
                end
                default:
                    emit = 1'b0;
            endcase
            if (emit)
            begin
                for (int k = 0; k < n; k++)
                    r.bytes[k] = fb[first + k];
                r.count = 3'(n);
                pending_payloads.insert(pending_payloads.size(), r);
                produced++;
            end
        endfunction

        function void compare_field(string name, int e, int a);
            if (e != a)
            begin
                $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        // Compare one delivered result with the oldest prediction
        function void match_result(result_t a);
            result_t e;
            if (pending_payloads.size() == 0)
            begin
                $display("%0t ns: unexpected result, kind %0h count %0h", $time,
                         a.kind, a.count);
                errors++;
                return;
            end
            e = pending_payloads.pop_front();
            compare_field("frame_kind", e.kind, a.kind);
            for (int k = 0; k < OUT_BYTES; k++)
                compare_field($sformatf("out_byte_%0d", k), e.bytes[k], a.bytes[k]);
            compare_field("byte_count", e.count, a.count);
            compare_field("message_end", e.msg_end, a.msg_end);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] pci_byte;
    logic [7:0] data_byte_1;
    logic [7:0] data_byte_2;
    logic [7:0] data_byte_3;
    logic [7:0] data_byte_4;
    logic [7:0] data_byte_5;
    logic [7:0] data_byte_6;
    logic [7:0] data_byte_7;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] frame_kind;
    logic [7:0] out_byte_0;
    logic [7:0] out_byte_1;
    logic [7:0] out_byte_2;
    logic [7:0] out_byte_3;
    logic [7:0] out_byte_4;
    logic [7:0] out_byte_5;
    logic [7:0] out_byte_6;
    logic [2:0] byte_count;
    logic       message_end;

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;

    isotp_tracker tracker = new();

    isotp_frame_reassembler_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pci_byte    (pci_byte),
        .data_byte_1 (data_byte_1),
        .data_byte_2 (data_byte_2),
        .data_byte_3 (data_byte_3),
        .data_byte_4 (data_byte_4),
        .data_byte_5 (data_byte_5),
        .data_byte_6 (data_byte_6),
        .data_byte_7 (data_byte_7),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_kind  (frame_kind),
        .out_byte_0  (out_byte_0),
        .out_byte_1  (out_byte_1),
        .out_byte_2  (out_byte_2),
        .out_byte_3  (out_byte_3),
        .out_byte_4  (out_byte_4),
        .out_byte_5  (out_byte_5),
        .out_byte_6  (out_byte_6),
        .byte_count  (byte_count),
        .message_end (message_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);

    // Observe both channels at the rising edge
    always @(posedge clk)
    begin
        frame_t  f;
        result_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                f.pci = pci_byte;
                f.data[1] = data_byte_1;
                f.data[2] = data_byte_2;
                f.data[3] = data_byte_3;
                f.data[4] = data_byte_4;
                f.data[5] = data_byte_5;
                f.data[6] = data_byte_6;
                f.data[7] = data_byte_7;
                tracker.take_frame(f);
            end
            if (out_valid && !out_stall)
            begin
                r.kind = frame_kind;
                r.bytes[0] = out_byte_0;
                r.bytes[1] = out_byte_1;
                r.bytes[2] = out_byte_2;
                r.bytes[3] = out_byte_3;
                r.bytes[4] = out_byte_4;
                r.bytes[5] = out_byte_5;
                r.bytes[6] = out_byte_6;
                r.count = byte_count;
                r.msg_end = message_end;
                tracker.match_result(r);
            end
        end
    end

    // Abort when neither channel moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic frame_t make_frame(logic [7:0] pci);
        frame_t f;
        f.pci = pci;
        for (int k = 1; k < 8; k++)
            f.data[k] = 8'($urandom);
        return f;
    endfunction

    // Present one request at the falling edge and hold it until taken
    task automatic send_frame(frame_t f);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        pci_byte    <= f.pci;
        data_byte_1 <= f.data[1];
        data_byte_2 <= f.data[2];
        data_byte_3 <= f.data[3];
        data_byte_4 <= f.data[4];
        data_byte_5 <= f.data[5];
        data_byte_6 <= f.data[6];
        data_byte_7 <= f.data[7];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pci(logic [7:0] pci);
        send_frame(make_frame(pci));
    endtask

    task automatic send_ff(logic [11:0] len);
        frame_t f;
        f = make_frame({PCI_TYPE_FF, len[11:8]});
        f.data[1] = len[7:0];
        send_frame(f);
    endtask

    task automatic send_fill(logic [7:0] pci, logic [7:0] fill);
        frame_t f;
        f.pci = pci;
        for (int k = 1; k < 8; k++)
            f.data[k] = fill;
        send_frame(f);
    endtask

    // One segmented message, sometimes cut short, overrun or interleaved
    task automatic send_message();
        logic [11:0] len;
        int          cfs;
        if ($urandom_range(0, 99) < 15)
        begin
            len = 12'($urandom);
            cfs = $urandom_range(0, 4);
        end
        else
        begin
            len = 12'($urandom_range(0, 48));
            cfs = (len <= 12'd6) ? 1 : (int'(len) - 6 + 6) / 7;
            if ($urandom_range(0, 99) < 10)
                cfs = cfs + 1;
            else if ($urandom_range(0, 99) < 10 && cfs > 0)
                cfs = cfs - 1;
        end
        send_ff(len);
        for (int i = 0; i < cfs; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_pci(8'($urandom));
            send_pci({PCI_TYPE_CF, 4'(i + 1)});
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pci_byte    = '0;
        data_byte_1 = '0;
        data_byte_2 = '0;
        data_byte_3 = '0;
        data_byte_4 = '0;
        data_byte_5 = '0;
        data_byte_6 = '0;
        data_byte_7 = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: single frame lengths, clamp and byte extremes
        send_pci({PCI_TYPE_SF, 4'h0});
        send_pci({PCI_TYPE_SF, 4'h7});
        send_pci({PCI_TYPE_SF, 4'hF});
        send_fill({PCI_TYPE_SF, 4'h7}, 8'hFF);
        send_fill({PCI_TYPE_SF, 4'h5}, 8'h00);
        // exact fit over two consecutive frames
        send_ff(12'd20);
        send_pci({PCI_TYPE_CF, 4'h1});
        send_pci({PCI_TYPE_CF, 4'h2});
        // long message, single frame in between, then abandoned by a short one
        send_ff(12'hFFF);
        send_pci({PCI_TYPE_SF, 4'h3});
        send_pci({PCI_TYPE_CF, 4'hF});
        send_ff(12'd3);
        send_pci({PCI_TYPE_CF, 4'h1});
        // zero-length first frame
        send_ff(12'd0);
        send_pci({PCI_TYPE_CF, 4'h1});
        // consecutive frame while idle and unknown types are dropped
        send_pci({PCI_TYPE_CF, 4'h0});
        send_pci(8'h30);
        send_pci(8'hF5);
        send_ff(12'd8);
        send_pci({PCI_TYPE_CF, 4'h1});
        send_ff(12'd13);
        send_pci({PCI_TYPE_CF, 4'h1});

        // Random traffic over the four idle/stall mixes
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 0;
                end
                1:
                begin
                    snd_idle_pct  = 70;
                    rcv_stall_pct = 0;
                end
                2:
                begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 70;
                end
                default:
                begin
                    snd_idle_pct  = 35;
                    rcv_stall_pct = 35;
                end
            endcase
            while (tracker.taken < (phase + 1) * RANDOM_ITEMS / 4)
            begin
                int pick;
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    send_pci({PCI_TYPE_SF, 4'($urandom)});
                else if (pick < 80)
                    send_message();
                else
                    send_pci(8'($urandom));
            end
        end
        in_valid <= 1'b0;

        // Drain, then wait for stray results before the verdict
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
